// ----- src/nearest_neighbour_tour_unit_defines.svh -----
`ifndef NEAREST_NEIGHBOUR_TOUR_UNIT_DEFINES_SVH
`define NEAREST_NEIGHBOUR_TOUR_UNIT_DEFINES_SVH

// Assertion helpers. They expect clk_i and rst_ni in the enclosing module.

`define NNT_ASSERT(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

`define NNT_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- src/nnt_pkg.sv -----
`timescale 1ns / 1ps

package nnt_pkg;

  localparam int FIELD_W     = 4;
  localparam int DIST_W      = 16;
  localparam int TOTAL_W     = 20;
  localparam int QUEUE_DEPTH = 2;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_RUN   = 1'b1
  } op_e;

  // One command held in the queue between the front and the back.
  typedef struct packed {
    op_e                op;
    logic [FIELD_W-1:0] row;
    logic [FIELD_W-1:0] col;
    logic [DIST_W-1:0]  distance;
    logic [FIELD_W-1:0] start_city;
  } cmd_t;

  // Saturating accumulation of one leg onto the tour length.
  function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                 input logic [DIST_W-1:0]  b);
    logic [TOTAL_W:0] sum;
    sum = {1'b0, a} + (TOTAL_W+1)'(b);
    return sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
  endfunction

endpackage

// ----- src/nnt_ifs.sv -----
`timescale 1ns / 1ps

interface nnt_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [3:0]  row;
  logic [3:0]  col;
  logic [15:0] distance;
  logic [3:0]  start_city;

  modport source (output valid, action, row, col, distance, start_city, input ready);
  modport sink   (input valid, action, row, col, distance, start_city, output ready);
endinterface

interface nnt_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  city;
  logic [19:0] total_distance;
  logic        last;

  modport source (output valid, city, total_distance, last, input ready);
  modport sink   (input valid, city, total_distance, last, output ready);
endinterface

// ----- src/nearest_neighbour_tour_unit.sv -----
`timescale 1ns / 1ps

// Greedy nearest-neighbor tour over a CITIES x CITIES distance matrix held in
// a single-port-read RAM. A write transaction stores one matrix entry; a run
// transaction emits CITIES results, the start city first, with the tour length
// including the return leg on the result marked last. Each step scans the
// current row one entry per cycle through the RAM read port. A two-entry
// command queue sits between input and engine, so new transactions are taken
// while a run is in progress until the queue fills. Every matrix entry must
// be written before a run reads it.
module nearest_neighbour_tour_unit #(
  parameter int CITIES = 16
) (
  input logic       clk_i,
  input logic       rst_ni,
  nnt_in_if.sink    in_i,
  nnt_out_if.source out_o
);
  import nnt_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic full;
  logic empty;
  logic pop;
  cmd_t pop_cmd;

  nnt_front #(
    .CITIES (CITIES)
  ) u_front (
    .in_i       (in_i),
    .full_i     (full),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  nnt_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .pop_cmd_o  (pop_cmd)
  );

  nnt_back #(
    .CITIES (CITIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!empty),
    .cmd_i       (pop_cmd),
    .cmd_pop_o   (pop),
    .out_o       (out_o)
  );

endmodule

// ----- src/nnt_ram.sv -----
`timescale 1ns / 1ps

module nnt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/nnt_fifo.sv -----
`timescale 1ns / 1ps
`include "nearest_neighbour_tour_unit_defines.svh"

module nnt_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  nnt_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output nnt_pkg::cmd_t pop_cmd_o
);
  import nnt_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  cmd_t             slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o    = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign pop_cmd_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  `NNT_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(QUEUE_DEPTH), "queue count beyond depth")
  `NNT_ASSERT(a_no_overflow, !(push_i && full_o), "push into a full queue")
  `NNT_ASSERT(a_no_underflow, !(pop_i && empty_o), "pop from an empty queue")

endmodule

// ----- src/nnt_front.sv -----
`timescale 1ns / 1ps

module nnt_front #(
  parameter int CITIES = 16
) (
  nnt_in_if.sink        in_i,
  input  logic          full_i,
  output logic          push_o,
  output nnt_pkg::cmd_t push_cmd_o
);
  import nnt_pkg::*;

  logic write_ok;
  logic run_ok;

  // Writes outside the matrix and runs from a nonexistent city are taken
  // and dropped here, so the back never sees them.
  assign write_ok = (int'(in_i.row) < CITIES) && (int'(in_i.col) < CITIES);
  assign run_ok   = (int'(in_i.start_city) < CITIES);

  assign in_i.ready = !full_i;

  always_comb begin
    push_cmd_o.op         = in_i.action ? OP_RUN : OP_WRITE;
    push_cmd_o.row        = in_i.row;
    push_cmd_o.col        = in_i.col;
    push_cmd_o.distance   = in_i.distance;
    push_cmd_o.start_city = in_i.start_city;
    push_o = in_i.valid && !full_i && (in_i.action ? run_ok : write_ok);
  end

endmodule

// ----- src/nnt_back.sv -----
`timescale 1ns / 1ps
`include "nearest_neighbour_tour_unit_defines.svh"

module nnt_back #(
  parameter int CITIES = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  nnt_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  nnt_out_if.source     out_o
);
  import nnt_pkg::*;

  localparam int CITY_W = $clog2(CITIES);
  localparam int DEPTH  = CITIES * CITIES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] CITIES_A  = ADDR_W'(CITIES);
  localparam logic [CITY_W-1:0] LAST_IDX  = CITY_W'(CITIES - 1);
  localparam logic [CITY_W-1:0] LAST_STEP = CITY_W'(CITIES - 2);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FIRST = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_STEP  = 3'd4;
  localparam logic [2:0] ST_RET   = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [CITIES-1:0]  visited_q, visited_d;
  logic [CITY_W-1:0]  cur_q, cur_d;
  logic [CITY_W-1:0]  start_q, start_d;
  logic [CITY_W-1:0]  scan_q, scan_d;
  logic [CITY_W-1:0]  step_q, step_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic               rd_vld_q, rd_vld_d;
  logic [CITY_W-1:0]  rd_idx_q, rd_idx_d;
  logic               found_q, found_d;
  logic [CITY_W-1:0]  best_q, best_d;
  logic [DIST_W-1:0]  best_dist_q, best_dist_d;

  logic               out_vld_q, out_vld_d;
  logic [3:0]         out_city_q, out_city_d;
  logic [TOTAL_W-1:0] out_total_q, out_total_d;
  logic               out_last_q, out_last_d;

  logic               out_free;
  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [DIST_W-1:0]  ram_rdata;
  logic [TOTAL_W-1:0] final_total;
  logic               emit_last;

  assign out_free    = !out_vld_q || out_o.ready;
  assign ram_waddr   = ADDR_W'(CITY_W'(cmd_i.row)) * CITIES_A + ADDR_W'(CITY_W'(cmd_i.col));
  assign final_total = sat_add(total_q, ram_rdata);
  assign emit_last   = (state_q == ST_RET) && out_free;

  nnt_ram #(
    .WIDTH (DIST_W),
    .DEPTH (DEPTH)
  ) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (cmd_i.distance),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    visited_d   = visited_q;
    cur_d       = cur_q;
    start_d     = start_q;
    scan_d      = scan_q;
    step_d      = step_q;
    total_d     = total_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = scan_q;
    found_d     = found_q;
    best_d      = best_q;
    best_dist_d = best_dist_q;
    out_vld_d   = out_vld_q && !out_o.ready;
    out_city_d  = out_city_q;
    out_total_d = out_total_q;
    out_last_d  = out_last_q;
    cmd_pop_o   = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = ADDR_W'(cur_q) * CITIES_A + ADDR_W'(scan_q);

    // Data read in the previous cycle is compared against the best so far.
    if (rd_vld_q && !visited_q[rd_idx_q] && (!found_q || ram_rdata < best_dist_q)) begin
      found_d     = 1'b1;
      best_d      = rd_idx_q;
      best_dist_d = ram_rdata;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.op == OP_WRITE) begin
            ram_we = 1'b1;
          end else begin
            start_d = CITY_W'(cmd_i.start_city);
            state_d = ST_FIRST;
          end
        end
      end
      ST_FIRST: begin
        if (out_free) begin
          out_vld_d   = 1'b1;
          out_city_d  = 4'(start_q);
          out_total_d = '0;
          out_last_d  = 1'b0;
          visited_d   = CITIES'(1) << start_q;
          cur_d       = start_q;
          total_d     = '0;
          step_d      = '0;
          scan_d      = '0;
          found_d     = 1'b0;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ram_re   = 1'b1;
        rd_vld_d = 1'b1;
        scan_d   = scan_q + 1'b1;
        if (scan_q == LAST_IDX) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_STEP;
      end
      ST_STEP: begin
        if (step_q == LAST_STEP) begin
          // Final city: fetch the return leg before the result goes out.
          visited_d = visited_q | (CITIES'(1) << best_q);
          total_d   = sat_add(total_q, best_dist_q);
          cur_d     = best_q;
          ram_re    = 1'b1;
          ram_raddr = ADDR_W'(best_q) * CITIES_A + ADDR_W'(start_q);
          state_d   = ST_RET;
        end else if (out_free) begin
          visited_d   = visited_q | (CITIES'(1) << best_q);
          total_d     = sat_add(total_q, best_dist_q);
          cur_d       = best_q;
          step_d      = step_q + 1'b1;
          out_vld_d   = 1'b1;
          out_city_d  = 4'(best_q);
          out_total_d = '0;
          out_last_d  = 1'b0;
          scan_d      = '0;
          found_d     = 1'b0;
          state_d     = ST_SCAN;
        end
      end
      ST_RET: begin
        if (out_free) begin
          total_d     = final_total;
          out_vld_d   = 1'b1;
          out_city_d  = 4'(cur_q);
          out_total_d = final_total;
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      visited_q <= '0;
      cur_q     <= '0;
      total_q   <= '0;
      rd_vld_q  <= 1'b0;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      visited_q <= visited_d;
      cur_q     <= cur_d;
      total_q   <= total_d;
      rd_vld_q  <= rd_vld_d;
      found_q   <= found_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q     <= start_d;
    scan_q      <= scan_d;
    step_q      <= step_d;
    rd_idx_q    <= rd_idx_d;
    best_q      <= best_d;
    best_dist_q <= best_dist_d;
    out_city_q  <= out_city_d;
    out_total_q <= out_total_d;
    out_last_q  <= out_last_d;
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.city           = out_city_q;
  assign out_o.total_distance = out_total_q;
  assign out_o.last           = out_last_q;

  `NNT_ASSERT_IMP(a_read_in_scan, rd_vld_q, state_q == ST_SCAN || state_q == ST_DRAIN, "stray read")
  `NNT_ASSERT_IMP(a_step_found, state_q == ST_STEP, found_q, "no unvisited city found")
  `NNT_ASSERT_IMP(a_last_all_visited, emit_last, visited_q == '1, "tour ends early")

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import nnt_pkg::*;

  localparam int CITY_COUNT       = 16;
  localparam int DIRECTED_ROWS    = 18;
  localparam int RANDOM_PER_PHASE = 44;
  localparam int PHASES           = 3;
  localparam int PRESSURE_PHASE   = 2;
  localparam int PRESSURE_RUNS    = 4;
  localparam int RUN_PCT          = 25;
  localparam int HOLD_CYCLES      = 1500;
  localparam int WATCHDOG_CYCLES  = 5000;
  localparam int DRAIN_CYCLES     = 300;
  localparam int SRC_IDLE_PCT [PHASES]  = '{8, 86, 0};
  localparam int SINK_IDLE_PCT [PHASES] = '{86, 8, 0};
  localparam logic [DIST_W-1:0] DIST_FAR = '1;

  // One city of an expected tour.
  typedef struct packed {
    logic [FIELD_W-1:0] city;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } tour_step_t;

  // One line of the directed plan; a typed tour lists the cities as nibbles,
  // the start city in the top nibble.
  typedef struct packed {
    cmd_t               cmd;
    logic               typed;
    logic [63:0]        tour;
    logic [TOTAL_W-1:0] total;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  nnt_in_if  cmd_if ();
  nnt_out_if tour_if ();

  nearest_neighbour_tour_unit #(
    .CITIES(CITY_COUNT)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_if),
    .out_o (tour_if)
  );

  always #5 clk_i = ~clk_i;

  logic [DIST_W-1:0] dist_mem [CITY_COUNT][CITY_COUNT];
  tour_step_t        tour_expect_q [$];
  int unsigned       fail_count = 0;
  int unsigned       writes_sent;
  int unsigned       tours_sent;
  int unsigned       cities_checked = 0;
  int unsigned       quiet_cycles = 0;
  int                src_idle_pct;
  int                sink_idle_pct;
  logic              pressure_go;
  logic              hold_sink;

  function automatic logic [TOTAL_W-1:0] add_leg(input logic [TOTAL_W-1:0] acc,
                                                 input logic [DIST_W-1:0]  leg);
    logic [TOTAL_W:0] sum;
    sum = {1'b0, acc} + {{(TOTAL_W + 1 - DIST_W){1'b0}}, leg};
    return sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
  endfunction

  // Greedy walk over the local matrix copy; strict less-than keeps the lower
  // index on ties.
  task automatic predict_tour(input logic [FIELD_W-1:0] start);
    logic [CITY_COUNT-1:0] visited;
    logic [FIELD_W-1:0]    here;
    logic [FIELD_W-1:0]    best;
    logic [DIST_W-1:0]     best_d;
    logic [TOTAL_W-1:0]    total;
    bit                    found;
    visited = '0;
    visited[start] = 1'b1;
    here  = start;
    total = '0;
    tour_expect_q.push_back('{start, '0, 1'b0});
    for (int step = 1; step < CITY_COUNT; step++) begin
      found  = 1'b0;
      best   = '0;
      best_d = '0;
      for (int c = 0; c < CITY_COUNT; c++) begin
        if (!visited[c] && (!found || dist_mem[here][c] < best_d)) begin
          found  = 1'b1;
          best_d = dist_mem[here][c];
          best   = FIELD_W'(c);
        end
      end
      visited[best] = 1'b1;
      total = add_leg(total, best_d);
      here  = best;
      tour_expect_q.push_back('{best, '0, 1'b0});
    end
    tour_expect_q[$].total = add_leg(total, dist_mem[here][start]);
    tour_expect_q[$].last  = 1'b1;
  endtask

  // Offers one command, waits for the transaction and records what it implies.
  task automatic apply_command(input cmd_t c, input logic typed,
                               input logic [63:0] tour, input logic [TOTAL_W-1:0] total);
    while ($urandom_range(99) < src_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.action     <= c.op;
    cmd_if.row        <= c.row;
    cmd_if.col        <= c.col;
    cmd_if.distance   <= c.distance;
    cmd_if.start_city <= c.start_city;
    do @(posedge clk_i); while (!cmd_if.ready);
    if (c.op == OP_WRITE) begin
      dist_mem[c.row][c.col] = c.distance;
      writes_sent++;
    end else begin
      tours_sent++;
      if (typed) begin
        for (int k = 0; k < CITY_COUNT; k++) begin
          tour_expect_q.push_back('{tour[63 - 4 * k -: 4],
                                    (k == CITY_COUNT - 1) ? total : '0,
                                    k == CITY_COUNT - 1});
        end
      end else begin
        predict_tour(c.start_city);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      tour_if.ready <= 1'b0;
    end else begin
      tour_if.ready <= !hold_sink && ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Long receiver hold-off so the command queue fills and the input stalls.
  initial begin
    hold_sink = 1'b0;
    wait (pressure_go);
    @(posedge clk_i);
    hold_sink <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_sink <= 1'b0;
  end

  always @(posedge clk_i) begin : result_check
    tour_step_t exp_step;
    if (rst_ni) begin
      if (tour_if.valid && tour_if.ready) begin
        if (tour_expect_q.size() == 0) begin
          $error("unexpected result: city %0d total %0d last %0b",
                 tour_if.city, tour_if.total_distance, tour_if.last);
          fail_count++;
        end else begin
          exp_step = tour_expect_q.pop_front();
          cities_checked++;
          if (tour_if.city !== exp_step.city) begin
            $error("city: expected %0d, got %0d", exp_step.city, tour_if.city);
            fail_count++;
          end
          if (tour_if.total_distance !== exp_step.total) begin
            $error("total_distance: expected %0d, got %0d",
                   exp_step.total, tour_if.total_distance);
            fail_count++;
          end
          if (tour_if.last !== exp_step.last) begin
            $error("last: expected %0b, got %0b", exp_step.last, tour_if.last);
            fail_count++;
          end
        end
      end
      if ((tour_if.valid && tour_if.ready) || (cmd_if.valid && cmd_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("Timeout: no transaction for %0d cycles.", quiet_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    cmd_t      cmd;
    plan_row_t directed_plan [DIRECTED_ROWS];
    // The matrix starts with every entry at the far extreme, so the first
    // tours follow index order and their totals are easy to state.
    directed_plan = '{
      '{'{OP_RUN,   4'd0,  4'd0,  16'd0,      4'd0},  1'b1, 64'h0123_4567_89AB_CDEF, 20'd1048560},
      '{'{OP_RUN,   4'd0,  4'd0,  16'd0,      4'd15}, 1'b1, 64'hF012_3456_789A_BCDE, 20'd1048560},
      '{'{OP_WRITE, 4'd15, 4'd7,  16'd0,      4'd0},  1'b0, 64'h0, 20'd0},
      '{'{OP_RUN,   4'd0,  4'd0,  16'd0,      4'd15}, 1'b1, 64'hF701_2345_689A_BCDE, 20'd983025},
      '{'{OP_WRITE, 4'd7,  4'd0,  16'd1,      4'd0},  1'b0, 64'h0, 20'd0},
      '{'{OP_WRITE, 4'd0,  4'd15, 16'd2,      4'd0},  1'b0, 64'h0, 20'd0},
      '{'{OP_WRITE, 4'd15, 4'd15, 16'd0,      4'd0},  1'b0, 64'h0, 20'd0},
      '{'{OP_WRITE, 4'd3,  4'd3,  16'h1234,   4'd0},  1'b0, 64'h0, 20'd0},
      '{'{OP_RUN,   4'd0,  4'd0,  16'd0,      4'd7},  1'b0, 64'h0, 20'd0},
      '{'{OP_WRITE, 4'd0,  4'd0,  16'hFFFF,   4'd0},  1'b0, 64'h0, 20'd0},
      '{'{OP_WRITE, 4'd5,  4'd9,  16'd100,    4'd0},  1'b0, 64'h0, 20'd0},
      '{'{OP_WRITE, 4'd5,  4'd2,  16'd100,    4'd0},  1'b0, 64'h0, 20'd0},
      '{'{OP_RUN,   4'd0,  4'd0,  16'd0,      4'd5},  1'b0, 64'h0, 20'd0},
      '{'{OP_RUN,   4'd0,  4'd0,  16'd0,      4'd3},  1'b0, 64'h0, 20'd0},
      '{'{OP_WRITE, 4'd8,  4'd4,  16'h8000,   4'd0},  1'b0, 64'h0, 20'd0},
      '{'{OP_WRITE, 4'd4,  4'd8,  16'h7FFF,   4'd0},  1'b0, 64'h0, 20'd0},
      '{'{OP_RUN,   4'd0,  4'd0,  16'd0,      4'd8},  1'b0, 64'h0, 20'd0},
      '{'{OP_RUN,   4'd0,  4'd0,  16'd0,      4'd4},  1'b0, 64'h0, 20'd0}
    };
    rst_ni              = 1'b0;
    pressure_go         = 1'b0;
    writes_sent         = 0;
    tours_sent          = 0;
    src_idle_pct        = SRC_IDLE_PCT[0];
    sink_idle_pct       = SINK_IDLE_PCT[0];
    cmd_if.valid        = 1'b0;
    cmd_if.action       = OP_WRITE;
    cmd_if.row          = '0;
    cmd_if.col          = '0;
    cmd_if.distance     = '0;
    cmd_if.start_city   = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Every entry has to be loaded before the first tour may read the matrix.
    for (int r = 0; r < CITY_COUNT; r++) begin
      for (int c = 0; c < CITY_COUNT; c++) begin
        cmd = '{OP_WRITE, FIELD_W'(r), FIELD_W'(c), DIST_FAR, '0};
        apply_command(cmd, 1'b0, '0, '0);
      end
    end

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      apply_command(directed_plan[i].cmd, directed_plan[i].typed,
                    directed_plan[i].tour, directed_plan[i].total);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      src_idle_pct  = SRC_IDLE_PCT[phase];
      sink_idle_pct <= SINK_IDLE_PCT[phase];
      if (phase == PRESSURE_PHASE) begin
        pressure_go = 1'b1;
      end
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        // Tours are stacked up front in the pressure phase to fill the queue.
        if ((phase == PRESSURE_PHASE && k < PRESSURE_RUNS) ||
            $urandom_range(99) < RUN_PCT) begin
          cmd.op = OP_RUN;
        end else begin
          cmd.op = OP_WRITE;
        end
        cmd.row        = FIELD_W'($urandom_range(CITY_COUNT - 1));
        cmd.col        = FIELD_W'($urandom_range(CITY_COUNT - 1));
        cmd.start_city = FIELD_W'($urandom_range(CITY_COUNT - 1));
        // Small values make ties between candidate cities likely.
        case ($urandom_range(3))
          0: cmd.distance = DIST_W'($urandom);
          1: cmd.distance = DIST_W'($urandom_range(15));
          2: cmd.distance = $urandom_range(1) ? DIST_FAR : '0;
          default: cmd.distance = DIST_W'($urandom_range(255));
        endcase
        apply_command(cmd, 1'b0, '0, '0);
      end
    end
    cmd_if.valid <= 1'b0;

    while (tour_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d matrix writes and %0d tours, %0d tour cities compared,",
             writes_sent, tours_sent, cities_checked);
    $display("with both sides idling in turn and one %0d-cycle receiver hold-off.",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
